@@ rtl/jsau_pkg.sv @@
package jsau_pkg;

  // Default depth of the command queue between front and back.
  localparam int JSAU_QUEUE_DEPTH = 4;

  // Hex character buffer of a \u escape.
  localparam int HEX_DEPTH = 4;
  localparam int HEX_IDX_W = $clog2(HEX_DEPTH);

  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_U      = 8'h75;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0] UTF8_CONT   = 8'h80;
  localparam logic [15:0] CP_LIM1    = 16'h0080;
  localparam logic [15:0] CP_LIM2    = 16'h0800;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       bad_hex;
    logic       run_last;
  } out_beat_t;

  typedef enum logic [1:0] {
    MODE_OUT,
    MODE_IN,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  typedef enum logic [1:0] {
    FS_RUN,
    FS_REPLAY,
    FS_FLUSH
  } fstate_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_END,
    KIND_BAD,
    KIND_UTF8
  } kind_t;

  // One queued command: expands into last_beat+1 output beats.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] data;
    logic [1:0]  last_beat;
    logic        str_end;
    logic        run_last;
  } cmd_t;

  // {valid, value} of one hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

@@ rtl/jsau_queue.sv @@
module jsau_queue
  import jsau_pkg::*;
#(
  parameter int DEPTH = JSAU_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/jsau_front.sv @@
module jsau_front
  import jsau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_push_data
);

  fstate_t              fs_r, fs_nxt;
  mode_t                mode_r;
  logic [HEX_IDX_W-1:0] hex_cnt_r;
  logic [7:0]           hex_chars_r [HEX_DEPTH];
  logic [HEX_IDX_W-1:0] rp_idx_r, rp_idx_nxt;
  logic [HEX_IDX_W-1:0] rp_last_r, rp_last_nxt;
  logic                 hold_v_r, hold_v_nxt;
  cmd_t                 hold_r, hold_nxt;
  logic                 step;

  // Character step: current byte, or a buffered hex char on replay.
  logic [7:0]           f_c;
  logic                 f_last;
  mode_t                f_mode;
  logic [HEX_IDX_W-1:0] f_cnt;
  logic                 f_prod;
  logic                 f_restart;
  logic                 f_wr;
  cmd_t                 f_cmd;
  cmd_t                 dec_cmd;
  logic [4:0]           h0, h1, h2, h3;
  logic [15:0]          cp;

  assign f_c    = (fs_r == FS_REPLAY) ? hex_chars_r[rp_idx_r] : in_data.in_byte;
  assign f_last = (fs_r == FS_REPLAY) ? (rp_idx_r == rp_last_r) : in_data.text_last;

  // \u decode: leading hex digits, last one is the incoming byte.
  always_comb begin
    h0 = hex_digit(hex_chars_r[0]);
    h1 = hex_digit(hex_chars_r[1]);
    h2 = hex_digit(hex_chars_r[2]);
    h3 = hex_digit(f_c);
    if (!h1[4]) begin
      cp = {12'h000, h0[3:0]};
    end else if (!h2[4]) begin
      cp = {8'h00, h0[3:0], h1[3:0]};
    end else if (!h3[4]) begin
      cp = {4'h0, h0[3:0], h1[3:0], h2[3:0]};
    end else begin
      cp = {h0[3:0], h1[3:0], h2[3:0], h3[3:0]};
    end
    dec_cmd.data      = cp;
    dec_cmd.str_end   = 1'b0;
    dec_cmd.run_last  = 1'b0;
    if (!h0[4]) begin
      dec_cmd.kind      = KIND_BAD;
      dec_cmd.last_beat = 2'd0;
    end else begin
      dec_cmd.kind = KIND_UTF8;
      if (cp < CP_LIM1) begin
        dec_cmd.last_beat = 2'd0;
      end else if (cp < CP_LIM2) begin
        dec_cmd.last_beat = 2'd1;
      end else begin
        dec_cmd.last_beat = 2'd2;
      end
    end
  end

  always_comb begin
    f_mode            = mode_r;
    f_cnt             = hex_cnt_r;
    f_prod            = 1'b0;
    f_restart         = 1'b0;
    f_wr              = 1'b0;
    f_cmd.kind        = KIND_BYTE;
    f_cmd.data        = {8'h00, f_c};
    f_cmd.last_beat   = 2'd0;
    f_cmd.str_end     = 1'b0;
    f_cmd.run_last    = 1'b0;
    unique case (mode_r)
      MODE_OUT: begin
        if (f_c == CHAR_QUOTE) f_mode = MODE_IN;
      end
      MODE_IN: begin
        if (f_c == CHAR_QUOTE) begin
          f_prod        = 1'b1;
          f_cmd.kind    = KIND_END;
          f_cmd.data    = '0;
          f_cmd.str_end = 1'b1;
          f_mode        = MODE_OUT;
        end else if (f_c == CHAR_BSLASH) begin
          if (f_last) f_prod = 1'b1;
          else        f_mode = MODE_ESC;
        end else begin
          f_prod = 1'b1;
        end
      end
      MODE_ESC: begin
        f_mode = MODE_IN;
        if (f_c == CHAR_N) begin
          f_prod     = 1'b1;
          f_cmd.data = {8'h00, BYTE_LF};
        end else if (f_c == CHAR_T) begin
          f_prod     = 1'b1;
          f_cmd.data = {8'h00, BYTE_TAB};
        end else if (f_c == CHAR_U) begin
          if (!f_last) begin
            f_mode = MODE_HEX;
            f_cnt  = '0;
          end
        end else begin
          f_prod = 1'b1;
        end
      end
      MODE_HEX: begin
        f_wr = 1'b1;
        if (hex_cnt_r == HEX_IDX_W'(HEX_DEPTH - 1)) begin
          f_cnt  = '0;
          f_mode = MODE_IN;
          f_prod = 1'b1;
          f_cmd  = dec_cmd;
        end else if (f_last) begin
          // text ended mid-escape: collected chars go back through as text
          f_restart = 1'b1;
          f_cnt     = '0;
          f_mode    = MODE_IN;
        end else begin
          f_cnt = hex_cnt_r + 1'b1;
        end
      end
      default: f_mode = MODE_OUT;
    endcase
    if (f_last && !f_restart) begin
      if (f_mode != MODE_OUT) begin
        if (f_prod) begin
          f_cmd.str_end = 1'b1;
        end else begin
          f_prod        = 1'b1;
          f_cmd.kind    = KIND_END;
          f_cmd.data    = '0;
          f_cmd.str_end = 1'b1;
        end
      end
      f_mode = MODE_OUT;
      f_cnt  = '0;
    end
  end

  // Replay results are held back one step so run_last lands on the final one.
  always_comb begin
    fs_nxt      = fs_r;
    rp_idx_nxt  = rp_idx_r;
    rp_last_nxt = rp_last_r;
    hold_v_nxt  = hold_v_r;
    hold_nxt    = hold_r;
    q_push      = 1'b0;
    q_push_data = f_cmd;
    step        = 1'b0;
    in_ready    = 1'b0;
    unique case (fs_r)
      FS_RUN: begin
        in_ready = !q_full;
        if (in_valid && !q_full) begin
          step = 1'b1;
          if (f_restart) begin
            fs_nxt      = FS_REPLAY;
            rp_idx_nxt  = '0;
            rp_last_nxt = hex_cnt_r;
            hold_v_nxt  = 1'b0;
          end else if (f_prod) begin
            q_push               = 1'b1;
            q_push_data.run_last = 1'b1;
          end
        end
      end
      FS_REPLAY: begin
        if (!q_full) begin
          step = 1'b1;
          if (f_prod) begin
            if (hold_v_r) begin
              q_push               = 1'b1;
              q_push_data          = hold_r;
              q_push_data.run_last = 1'b0;
            end
            hold_nxt   = f_cmd;
            hold_v_nxt = 1'b1;
          end
          if (f_last) begin
            if (f_restart) begin
              rp_idx_nxt  = '0;
              rp_last_nxt = hex_cnt_r;
            end else begin
              fs_nxt = FS_FLUSH;
            end
          end else begin
            rp_idx_nxt = rp_idx_r + 1'b1;
          end
        end
      end
      FS_FLUSH: begin
        if (!hold_v_r) begin
          fs_nxt = FS_RUN;
        end else if (!q_full) begin
          q_push               = 1'b1;
          q_push_data          = hold_r;
          q_push_data.run_last = 1'b1;
          hold_v_nxt           = 1'b0;
          fs_nxt               = FS_RUN;
        end
      end
      default: fs_nxt = FS_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r      <= FS_RUN;
      mode_r    <= MODE_OUT;
      hex_cnt_r <= '0;
      rp_idx_r  <= '0;
      rp_last_r <= '0;
      hold_v_r  <= 1'b0;
    end else begin
      fs_r      <= fs_nxt;
      rp_idx_r  <= rp_idx_nxt;
      rp_last_r <= rp_last_nxt;
      hold_v_r  <= hold_v_nxt;
      if (step) begin
        mode_r    <= f_mode;
        hex_cnt_r <= f_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (step && f_wr) begin
      hex_chars_r[hex_cnt_r] <= f_c;
    end
  end

endmodule

@@ rtl/jsau_back.sv @@
module jsau_back
  import jsau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic [1:0] beat_r, beat_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_r, out_nxt;
  logic       is_last, load;

  assign is_last   = (beat_r == head.last_beat);
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && is_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_nxt.out_byte   = 8'h00;
    out_nxt.has_byte   = 1'b0;
    out_nxt.bad_hex    = 1'b0;
    out_nxt.string_end = head.str_end && is_last;
    out_nxt.run_last   = head.run_last && is_last;
    unique case (head.kind)
      KIND_BYTE: begin
        out_nxt.has_byte = 1'b1;
        out_nxt.out_byte = head.data[7:0];
      end
      KIND_END: begin
        out_nxt.has_byte = 1'b0;
      end
      KIND_BAD: begin
        out_nxt.bad_hex = 1'b1;
      end
      KIND_UTF8: begin
        out_nxt.has_byte = 1'b1;
        priority if (head.last_beat == 2'd0) begin
          out_nxt.out_byte = head.data[7:0];
        end else if (is_last) begin
          out_nxt.out_byte = UTF8_CONT | {2'b00, head.data[5:0]};
        end else if (head.last_beat == 2'd1) begin
          out_nxt.out_byte = UTF8_LEAD2 | {3'b000, head.data[10:6]};
        end else if (beat_r == 2'd0) begin
          out_nxt.out_byte = UTF8_LEAD3 | {4'h0, head.data[15:12]};
        end else begin
          out_nxt.out_byte = UTF8_CONT | {2'b00, head.data[11:6]};
        end
      end
      default: out_nxt.has_byte = 1'b0;
    endcase
  end

  always_comb begin
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      beat_nxt      = is_last ? 2'd0 : beat_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ rtl/json_string_array_unescape.sv @@
// Channel  Ports                          Beat          Accepted when
// input    in_valid in_ready in_data      in_beat_t     in_valid && in_ready
// result   out_valid out_ready out_data   out_beat_t    out_valid && out_ready
//
// One input byte per cycle in normal text while the queue has room; each byte
// makes zero or one result beat, a completed \u escape makes one to three,
// sent by the back end one beat a cycle while out_ready is high and the
// command queue keeps the front taking bytes. Text ending inside a \u escape
// stops input while the buffered characters are rescanned and the held
// result is flushed (a rescan that again ends inside \u rescans its single
// hex character once more), for longer if the queue is full.
// Reset (rst_n low, synchronous) clears parse mode, queue and output valid;
// no clearing pass, the hex buffer is always written before it is read.
// Either side may stall: a full queue drops in_ready, out_ready low holds the
// output register and the back end.
module json_string_array_unescape
  import jsau_pkg::*;
#(
  parameter int QUEUE_DEPTH = JSAU_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  // front -> queue
  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  // queue -> back
  cmd_t q_head;
  logic q_head_valid;
  logic q_pop;

  // Front: parses the byte stream, at most one command per parsed character.
  jsau_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  jsau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  // Back: expands commands (UTF-8 sequences included) into result beats.
  jsau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ tb/sv/json_string_array_unescape_tb.sv @@
module json_string_array_unescape_tb;
  import jsau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run bounds. The slowest legal run (every byte making its most beats, each
  // waiting out long receiver gaps plus the long hold-off) is far below this.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL  = 16;    // queue depth plus pipeline, with margin
  localparam int LONG_STALL  = 300;   // receiver hold-off, in cycles
  localparam int MAX_BEATS   = 4;     // upper bound on beats one input byte can cause
  localparam int MAX_REPORTS = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  json_string_array_unescape i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Unescape predictor: own copy of the parser state.
  // ---------------------------------------------------------------------
  mode_t      scan_mode = MODE_OUT;
  logic [2:0] hex_fill = '0;
  logic [7:0] hex_buf [4];

  out_beat_t  step_beats[$];      // beats of the byte being predicted
  out_beat_t  expected_beats[$];  // beats still owed by the block

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  logic [7:0] text_q[$];          // bytes of the text being built

  // Hex digit value, -1 when not a digit.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic has,
                                    input logic send, input logic bad);
    out_beat_t r;
    if (step_beats.size() >= MAX_BEATS) return;
    r.out_byte   = b;
    r.has_byte   = has;
    r.string_end = send;
    r.bad_hex    = bad;
    r.run_last   = 1'b0;
    step_beats.insert(step_beats.size(), r);
  endfunction

  // Four buffered characters -> 1..3 UTF-8 beats, or a bad-hex beat.
  function automatic void emit_code_point();
    logic [15:0] cp;
    int          k;
    int          v;
    bit          more;
    cp = '0;
    if (hex_nibble(hex_buf[0]) < 0) begin
      push_beat(8'h00, 1'b0, 1'b0, 1'b1);
      return;
    end
    k = 0;
    more = 1'b1;
    while (more && k < 4) begin
      v = hex_nibble(hex_buf[k]);
      if (v < 0) begin
        more = 1'b0;
      end else begin
        cp = {cp[11:0], 4'(v)};
        k++;
      end
    end
    if (cp < CP_LIM1) begin
      push_beat(cp[7:0], 1'b1, 1'b0, 1'b0);
    end else if (cp < CP_LIM2) begin
      push_beat(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b1, 1'b0, 1'b0);
      push_beat(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end else begin
      push_beat(UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b1, 1'b0, 1'b0);
      push_beat(UTF8_CONT | {2'b00, cp[11:6]}, 1'b1, 1'b0, 1'b0);
      push_beat(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  // One text byte through the parser. Recursive: a text ending inside a
  // \u escape rescans the buffered characters as plain string bytes.
  function automatic void unescape_byte(input logic [7:0] c, input bit last);
    int         first_idx;
    int         n;
    int         k;
    logic [7:0] saved [4];
    out_beat_t  r;
    first_idx = step_beats.size();
    case (scan_mode)
      MODE_OUT: begin
        if (c == CHAR_QUOTE) scan_mode = MODE_IN;
      end
      MODE_IN: begin
        if (c == CHAR_QUOTE) begin
          push_beat(8'h00, 1'b0, 1'b1, 1'b0);
          scan_mode = MODE_OUT;
        end else if (c == CHAR_BSLASH) begin
          if (last) push_beat(CHAR_BSLASH, 1'b1, 1'b0, 1'b0);
          else scan_mode = MODE_ESC;
        end else begin
          push_beat(c, 1'b1, 1'b0, 1'b0);
        end
      end
      MODE_ESC: begin
        scan_mode = MODE_IN;
        if (c == CHAR_N) begin
          push_beat(BYTE_LF, 1'b1, 1'b0, 1'b0);
        end else if (c == CHAR_T) begin
          push_beat(BYTE_TAB, 1'b1, 1'b0, 1'b0);
        end else if (c == CHAR_U) begin
          if (!last) begin
            scan_mode = MODE_HEX;
            hex_fill = '0;
          end
        end else begin
          push_beat(c, 1'b1, 1'b0, 1'b0);
        end
      end
      default: begin
        hex_buf[hex_fill[1:0]] = c;
        hex_fill = hex_fill + 3'd1;
        if (hex_fill >= 3'd4) begin
          hex_fill = '0;
          scan_mode = MODE_IN;
          emit_code_point();
        end else if (last) begin
          n = int'(hex_fill);
          saved = hex_buf;
          hex_fill = '0;
          scan_mode = MODE_IN;
          for (k = 0; k < n; k++) unescape_byte(saved[k], k + 1 == n);
          return;
        end
      end
    endcase
    // End of text closes an open string on its last beat, or an empty one.
    if (last) begin
      if (scan_mode != MODE_OUT) begin
        if (step_beats.size() > first_idx) begin
          r = step_beats.pop_back();
          r.string_end = 1'b1;
          step_beats.insert(step_beats.size(), r);
        end else begin
          push_beat(8'h00, 1'b0, 1'b1, 1'b0);
        end
      end
      scan_mode = MODE_OUT;
      hex_fill = '0;
    end
  endfunction

  task automatic predict_byte(input logic [7:0] b, input bit last);
    out_beat_t r;
    step_beats.delete();
    unescape_byte(b, last);
    if (step_beats.size() > 0) begin
      r = step_beats.pop_back();
      r.run_last = 1'b1;
      step_beats.insert(step_beats.size(), r);
    end
    foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
  endtask

  // ---------------------------------------------------------------------
  // Sender: one byte per call, random idle cycles before the offer.
  // Valid stays up back to back when no idle is drawn.
  // ---------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, text_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_byte(b, last);
  endtask

  // Whole text from a string literal; final byte carries text_last.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  task automatic send_text_q();
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Drop valid, let every owed beat arrive, then a short tail for late extras.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready, or a long counted hold-off on request.
  // ---------------------------------------------------------------------
  logic stall_req = 1'b0;
  logic stall_seen = 1'b0;
  int   stall_left = 0;

  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: each accepted beat against the oldest expectation.
  // ---------------------------------------------------------------------
  out_beat_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected beat byte=%02h has=%b end=%b bad=%b last=%b",
                   $time, out_data.out_byte, out_data.has_byte, out_data.string_end,
                   out_data.bad_hex, out_data.run_last);
      end else begin
        want = expected_beats.pop_front();
        if (want.out_byte !== out_data.out_byte || want.has_byte !== out_data.has_byte ||
            want.string_end !== out_data.string_end || want.bad_hex !== out_data.bad_hex ||
            want.run_last !== out_data.run_last) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: mismatch expected %02h/%b%b%b%b actual %02h/%b%b%b%b",
                     $time, want.out_byte, want.has_byte, want.string_end, want.bad_hex,
                     want.run_last, out_data.out_byte, out_data.has_byte,
                     out_data.string_end, out_data.bad_hex, out_data.run_last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("json_string_array_unescape regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Random text builder.
  // ---------------------------------------------------------------------
  function automatic void text_add(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return "0" + v;
    return (upper ? "A" : "a") + v - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_nibble(c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    return hex_ascii(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  // One piece of string body: plain byte or one of the escape forms.
  function automatic void add_token();
    int          pick;
    int          nd;
    logic [7:0]  b;
    logic [15:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_QUOTE || b == CHAR_BSLASH) b = b ^ 8'h01;
      text_add(b);
    end else if (pick < 50) begin
      text_add(CHAR_BSLASH);
      text_add(CHAR_N);
    end else if (pick < 58) begin
      text_add(CHAR_BSLASH);
      text_add(CHAR_T);
    end else if (pick < 68) begin
      // literal escape, any byte (quote and backslash included)
      text_add(CHAR_BSLASH);
      text_add(8'($urandom_range(0, 255)));
    end else begin
      text_add(CHAR_BSLASH);
      text_add(CHAR_U);
      if (pick < 88) begin
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(0, 16'h007F));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        for (int k = 3; k >= 0; k--)
          text_add(hex_ascii(cp[4*k +: 4], 1'($urandom_range(0, 1))));
      end else if (pick < 94) begin
        // first character not a digit
        text_add(non_hex_char());
        repeat (3) text_add(rand_hex_char());
      end else begin
        // leading digits then a stop character
        nd = $urandom_range(1, 3);
        repeat (nd) text_add(rand_hex_char());
        text_add(non_hex_char());
        repeat (3 - nd) text_add(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Mostly well-formed arrays of strings; some noise, some cut short.
  function automatic void build_random_text();
    int         n_elem;
    int         cut;
    logic [7:0] b;
    text_q.delete();
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 8)) text_add(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_QUOTE) b = b ^ 8'h01;
      text_add(b);
    end
    n_elem = $urandom_range(1, 3);
    for (int e = 0; e < n_elem; e++) begin
      text_add(CHAR_QUOTE);
      repeat ($urandom_range(0, 5)) add_token();
      // last element sometimes left open: end of text closes it
      if (e + 1 < n_elem || $urandom_range(0, 99) < 85) text_add(CHAR_QUOTE);
      if (e + 1 < n_elem && $urandom_range(0, 1)) text_add(8'h2C);
    end
    // truncation lands the end of text inside escapes and hex runs
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, text_q.size());
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Skip outside strings, byte extremes, \t \n, literal escape, close quote.
  task automatic test_skip_and_escapes();
    send_beat(8'hFF, 1'b0);
    send_beat(CHAR_QUOTE, 1'b0);
    send_beat(8'h00, 1'b0);
    send_text("\\t\\n\\\"z\"");
  endtask

  // Two-byte UTF-8, non-hex first char, digits cut short, three-byte
  // UTF-8 whose fourth character is the last byte of the text.
  task automatic test_unicode_escapes();
    send_text("\"\\u00e9\\uz123\\u4g00\\u20AC");
  endtask

  // Quote, backslash, \u and a partial hex run as the final bytes.
  task automatic test_text_end_cases();
    send_text("\"");
    send_text("\"\\");
    send_text("\"\\u");
    send_text("\"\\u4\\");
  endtask

  task automatic test_random_text(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      build_random_text();
      send_text_q();
    end
  endtask

  // Receiver holds off for a long stretch while bytes keep coming, so the
  // command queue fills and in_ready drops.
  task automatic test_output_backpressure(input int count);
    stall_req <= ~stall_req;
    test_random_text(count);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct <= 61;
    test_skip_and_escapes();
    test_unicode_escapes();
    test_text_end_cases();
    wait_drained();

    test_random_text(120);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct <= 37;
    test_random_text(120);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_output_backpressure(120);
    wait_drained();

    if (err_cnt == 0) begin
      $display("json_string_array_unescape regression: pass");
    end else begin
      $display("json_string_array_unescape regression: fail");
    end
    $finish;
  end

endmodule
